@@ hdl/stbp_pkg.sv @@
// stbp_pkg: shared types, constants and the symbol code table for the
// symbol-to-bit packer. No dependencies.
`default_nettype none

package stbp_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [16:0] INDEX_MAX     = 17'h1FFFF;
  localparam logic [15:0] MAX_BYTES_RST = 16'd256;

  localparam logic [7:0] SYM_4     = 8'h34;
  localparam logic [7:0] SYM_V     = 8'h76;
  localparam logic [7:0] SYM_DASH  = 8'h2D;
  localparam logic [7:0] SYM_K     = 8'h6B;
  localparam logic [7:0] SYM_S     = 8'h73;
  localparam logic [7:0] SYM_UP_Y  = 8'h59;
  localparam logic [7:0] SYM_P     = 8'h70;
  localparam logic [7:0] SYM_AT    = 8'h40;
  localparam logic [7:0] SYM_N     = 8'h6E;
  localparam logic [7:0] SYM_5     = 8'h35;
  localparam logic [7:0] SYM_3     = 8'h33;
  localparam logic [7:0] SYM_UP_F  = 8'h46;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic        byte_valid;
    logic        last;
  } result_t;

  // Results of one input transfer: one or two.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic [1:0] len;
    logic [2:0] pat;
  } code_t;

  function automatic code_t lookup(input logic [7:0] sym);
    code_t c;
    c = '0;
    case (sym)
      SYM_4:    c = '{len: 2'd3, pat: 3'd0};
      SYM_V:    c = '{len: 2'd3, pat: 3'd1};
      SYM_DASH: c = '{len: 2'd3, pat: 3'd2};
      SYM_K:    c = '{len: 2'd3, pat: 3'd3};
      SYM_S:    c = '{len: 2'd3, pat: 3'd4};
      SYM_UP_Y: c = '{len: 2'd3, pat: 3'd5};
      SYM_P:    c = '{len: 2'd3, pat: 3'd6};
      SYM_AT:   c = '{len: 2'd3, pat: 3'd7};
      SYM_N:    c = '{len: 2'd2, pat: 3'd0};
      SYM_5:    c = '{len: 2'd2, pat: 3'd1};
      SYM_3:    c = '{len: 2'd2, pat: 3'd2};
      SYM_UP_F: c = '{len: 2'd2, pat: 3'd3};
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/symbol_to_bit_packer.sv @@
// symbol_to_bit_packer: top level; input register, bit packing logic and
// state, max_bytes register. Depends on stbp_pkg and stbp_result_queue.
`default_nettype none

// One symbol is taken per clock unless the result queue is full. Its code is
// merged into the partial byte in a single registered step between the input
// register and a four-entry result queue, so a new symbol may transfer every
// cycle while results drain. Most symbols give zero or one result; the
// end-of-string symbol that both completes a byte and flushes a partial one
// gives two. Sustained rate is one symbol per cycle as long as the output
// takes one result per cycle on average; each result passes the input
// register and the result queue. Write max_bytes only while idle.

module symbol_to_bit_packer
  import stbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_end_of_string,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte_value,
  output logic [15:0]      out_byte_index,
  output logic             out_byte_valid,
  output logic             out_last
);

  logic        s1_v_r;
  logic [7:0]  sym_r;
  logic        end_r;
  logic [15:0] max_r;
  logic [7:0]  pb_r;
  logic [2:0]  bp_r;
  logic [16:0] idx_r;

  code_t       code;
  logic [3:0]  total;
  logic [4:0]  sh;
  logic [15:0] acc;
  logic        done;
  logic [7:0]  pb_nxt;
  logic [2:0]  bp_nxt;
  logic [16:0] idx_inc, idx1;
  logic        e1, e2, flush;
  result_t     r1, r2;
  entry_t      ent;
  logic        adv, push, q_full, in_xfer;

  assign adv      = s1_v_r && !q_full;
  assign in_stall = s1_v_r && q_full;
  assign in_xfer  = in_valid && !in_stall;

  assign code    = lookup(sym_r);
  assign total   = {1'b0, bp_r} + {2'b00, code.len};
  assign sh      = 5'd16 - {2'b00, bp_r} - {3'b000, code.len};
  assign acc     = {pb_r, 8'h00} | ({13'b0, code.pat} << sh);
  assign done    = total[3];
  assign pb_nxt  = done ? acc[7:0] : acc[15:8];
  assign bp_nxt  = total[2:0];
  assign idx_inc = (idx_r != INDEX_MAX) ? idx_r + 17'd1 : idx_r;
  assign idx1    = done ? idx_inc : idx_r;
  assign e1      = done && (idx_r < {1'b0, max_r});
  assign flush   = end_r && (bp_nxt != 3'd0);
  assign e2      = flush && (idx1 < {1'b0, max_r});

  assign r1 = '{byte_value: acc[15:8], byte_index: idx_r[15:0],
                byte_valid: 1'b1, last: end_r && !e2};
  assign r2 = '{byte_value: pb_nxt, byte_index: idx1[15:0],
                byte_valid: 1'b1, last: 1'b1};

  always_comb begin
    ent = '0;
    if (e1 && e2) begin
      ent.first  = r1;
      ent.second = r2;
      ent.two    = 1'b1;
    end else if (e1) begin
      ent.first = r1;
    end else if (e2) begin
      ent.first = r2;
    end else begin
      ent.first.last = 1'b1;  // bare end marker
    end
  end

  assign push = adv && (e1 || e2 || end_r);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sym_r <= in_symbol;
      end_r <= in_end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      max_r  <= MAX_BYTES_RST;
      pb_r   <= '0;
      bp_r   <= '0;
      idx_r  <= '0;
    end else begin
      if (in_xfer) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (adv) begin
        if (end_r) begin
          pb_r  <= '0;
          bp_r  <= '0;
          idx_r <= '0;
        end else begin
          pb_r  <= pb_nxt;
          bp_r  <= bp_nxt;
          idx_r <= idx1;
        end
      end
    end
  end

  stbp_result_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_ent       (ent),
    .full           (q_full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_value (out_byte_value),
    .out_byte_index (out_byte_index),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && end_r) |=> (bp_r == 3'd0 && pb_r == 8'h00 && idx_r == 17'd0))
    else $error("string state not cleared after end item");

  a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && ent.two) |-> end_r)
    else $error("two results from a non-end item");

endmodule

`default_nettype wire

@@ hdl/stbp_result_queue.sv @@
// stbp_result_queue: small queue of per-item result groups that hands out
// one result per output transfer. Depends on stbp_pkg.
`default_nettype none

module stbp_result_queue
  import stbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire entry_t      push_ent,
  output logic             full,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte_value,
  output logic [15:0]      out_byte_index,
  output logic             out_byte_valid,
  output logic             out_last
);

  entry_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                sub_r;
  entry_t              head;
  result_t             res;
  logic                xfer, pop;

  assign head      = ent_r[rd_ptr_r];
  assign res       = sub_r ? head.second : head.first;
  assign out_valid = (cnt_r != '0);
  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign xfer      = out_valid && !out_stall;
  assign pop       = xfer && (!head.two || sub_r);

  assign out_byte_value = res.byte_value;
  assign out_byte_index = res.byte_index;
  assign out_byte_valid = res.byte_valid;
  assign out_last       = res.last;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
        sub_r    <= 1'b0;
      end else if (xfer) begin
        sub_r <= 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full result queue");

  a_sub_two: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (out_valid && head.two))
    else $error("second result selected on single-result entry");

endmodule

`default_nettype wire

@@ tb/sv/symbol_to_bit_packer_checker.sv @@
// symbol_to_bit_packer_checker: watches the ports of symbol_to_bit_packer,
// predicts the packed bytes of every input transfer and compares each output
// transfer in order. Depends on stbp_pkg.
`timescale 1ns / 1ps

module symbol_to_bit_packer_checker
  import stbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_end_of_string,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_byte_value,
  input  wire logic [15:0] out_byte_index,
  input  wire logic        out_byte_valid,
  input  wire logic        out_last,
  output int               mismatch_count,
  output int               pending_results
);

  result_t     expected_bytes[$];
  result_t     staged[2];
  int          staged_count;
  logic [15:0] buffer_limit;
  logic [7:0]  partial_byte;
  int          fill_bits;
  logic [16:0] next_index;

  assign pending_results = expected_bytes.size();

  task automatic report_mismatch(input string what);
    if (mismatch_count < 50) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic int decode_symbol(input logic [7:0] sym, output logic [2:0] code);
    code = 3'd0;
    case (sym)
      SYM_4:    begin code = 3'd0; return 3; end
      SYM_V:    begin code = 3'd1; return 3; end
      SYM_DASH: begin code = 3'd2; return 3; end
      SYM_K:    begin code = 3'd3; return 3; end
      SYM_S:    begin code = 3'd4; return 3; end
      SYM_UP_Y: begin code = 3'd5; return 3; end
      SYM_P:    begin code = 3'd6; return 3; end
      SYM_AT:   begin code = 3'd7; return 3; end
      SYM_N:    begin code = 3'd0; return 2; end
      SYM_5:    begin code = 3'd1; return 2; end
      SYM_3:    begin code = 3'd2; return 2; end
      SYM_UP_F: begin code = 3'd3; return 2; end
      default:  return 0;
    endcase
  endfunction

  // bytes at or past the buffer limit are dropped, the index still advances (saturating at INDEX_MAX)
  task automatic store_byte();
    if (next_index < {1'b0, buffer_limit}) begin
      staged[staged_count] = '{byte_value: partial_byte, byte_index: next_index[15:0],
                               byte_valid: 1'b1, last: 1'b0};
      staged_count++;
    end
    if (next_index != INDEX_MAX) begin
      next_index++;
    end
  endtask

  task automatic predict_transfer(input logic [7:0] sym, input logic eos);
    logic [2:0] code;
    int         width;
    staged_count = 0;
    width = decode_symbol(sym, code);
    for (int i = width - 1; i >= 0; i--) begin
      partial_byte[7 - fill_bits] = code[i];
      fill_bits++;
      if (fill_bits == 8) begin
        store_byte();
        partial_byte = '0;
        fill_bits = 0;
      end
    end
    if (eos) begin
      if (fill_bits != 0) begin
        store_byte();
      end
      if (staged_count == 0) begin
        staged[0] = '{byte_value: 8'h00, byte_index: 16'h0000, byte_valid: 1'b0,
                      last: 1'b1};
        staged_count = 1;
      end else begin
        staged[staged_count - 1].last = 1'b1;
      end
      partial_byte = '0;
      fill_bits = 0;
      next_index = '0;
    end
    for (int k = 0; k < staged_count; k++) begin
      expected_bytes.push_back(staged[k]);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer value %02h index %0d valid %0b last %0b",
                                out_byte_value, out_byte_index, out_byte_valid, out_last));
    end else begin
      want = expected_bytes.pop_front();
      if (out_byte_value !== want.byte_value) begin
        report_mismatch($sformatf("byte_value %02h, want %02h (index %0d)",
                                  out_byte_value, want.byte_value, want.byte_index));
      end
      if (out_byte_index !== want.byte_index) begin
        report_mismatch($sformatf("byte_index %0d, want %0d",
                                  out_byte_index, want.byte_index));
      end
      if (out_byte_valid !== want.byte_valid) begin
        report_mismatch($sformatf("byte_valid %0b, want %0b (index %0d)",
                                  out_byte_valid, want.byte_valid, want.byte_index));
      end
      if (out_last !== want.last) begin
        report_mismatch($sformatf("last %0b, want %0b (index %0d)",
                                  out_last, want.last, want.byte_index));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      buffer_limit = MAX_BYTES_RST;
      partial_byte = '0;
      fill_bits = 0;
      next_index = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        buffer_limit = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        predict_transfer(in_symbol, in_end_of_string);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
    end
  end

endmodule

@@ tb/sv/symbol_to_bit_packer_test.sv @@
// symbol_to_bit_packer_test: top of the testbench; clock, reset, symbol
// strings, max_bytes settings and output stalls for symbol_to_bit_packer.
// Depends on stbp_pkg, symbol_to_bit_packer and symbol_to_bit_packer_checker.
`timescale 1ns / 1ps

module symbol_to_bit_packer_test
  import stbp_pkg::*;
();

  localparam int RUN_LIMIT       = 400000;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int SETTLE_CYCLES   = 8;
  localparam int BACKLOG_CYCLES  = 400;
  localparam int DIRECTED_COUNT  = 23;

  localparam logic [7:0] THREE_BIT_SYMS [8] = '{SYM_4, SYM_V, SYM_DASH, SYM_K,
                                                SYM_S, SYM_UP_Y, SYM_P, SYM_AT};
  localparam logic [7:0] TWO_BIT_SYMS [4] = '{SYM_N, SYM_5, SYM_3, SYM_UP_F};

  // all codes in one string; unknown alone; flush of a partial byte;
  // end item that completes one byte and flushes another
  localparam logic [7:0] DIRECTED_SYMS [DIRECTED_COUNT] = '{
    SYM_4, SYM_V, SYM_DASH, SYM_K, SYM_S, SYM_UP_Y, SYM_P, SYM_AT,
    SYM_N, SYM_5, SYM_3, SYM_UP_F,
    8'h00,
    8'hFF, SYM_AT,
    SYM_N, SYM_5, SYM_3, SYM_AT,
    SYM_4,
    8'h7F, SYM_UP_F, 8'h80};
  localparam logic DIRECTED_ENDS [DIRECTED_COUNT] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b1,
    1'b0, 1'b0, 1'b1};

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_symbol;
  logic        in_end_of_string;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte_value;
  logic [15:0] out_byte_index;
  logic        out_byte_valid;
  logic        out_last;
  int          mismatch_count;
  int          pending_results;
  int          cycle_count;
  int          burst_left;
  bit          backlog_req;

  symbol_to_bit_packer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_symbol        (in_symbol),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_value   (out_byte_value),
    .out_byte_index   (out_byte_index),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last)
  );

  symbol_to_bit_packer_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_symbol        (in_symbol),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_value   (out_byte_value),
    .out_byte_index   (out_byte_index),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output stall: segments of varying density, plus one long hold-off
  initial begin
    int   mode;
    int   seg_len;
    logic hold;
    hold = 1'b0;
    forever begin
      if (backlog_req) begin
        backlog_req = 1'b0;
        out_stall <= 1'b1;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        seg_len = $urandom_range(10, 80);
        repeat (seg_len) begin
          case (mode)
            0:       hold = 1'b0;
            1:       hold = ($urandom_range(0, 3) == 0);
            2:       hold = ($urandom_range(0, 3) != 0);
            default: hold = ~hold;
          endcase
          out_stall <= hold;
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [7:0] random_symbol();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return THREE_BIT_SYMS[$urandom_range(0, 7)];
    end else if (pick < 85) begin
      return TWO_BIT_SYMS[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [7:0] sym, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_symbol <= sym;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
  endtask

  // drain: all predicted bytes out, then let symbols without output settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_bytes(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] phase_limit(input int phase);
    case (phase)
      0:       return 16'hFFFF;
      1:       return 16'd0;
      2:       return 16'd1;
      3:       return 16'd2;
      4:       return 16'($urandom_range(3, 8));
      5:       return 16'($urandom_range(9, 40));
      6:       return 16'($urandom_range(0, 65535));
      default: return MAX_BYTES_RST;
    endcase
  endfunction

  initial begin
    int sent;
    int str_len;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_symbol <= '0;
    in_end_of_string <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_item(DIRECTED_SYMS[i], DIRECTED_ENDS[i]);
    end
    wait_idle();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_max_bytes(phase_limit(phase));
      if (phase == 0) begin
        backlog_req = 1'b1;
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 24);
        for (int j = 0; j < str_len; j++) begin
          send_item(random_symbol(), j == str_len - 1);
        end
        sent += str_len;
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
